@@ src/pse_pkg.sv @@
// Shared constants, codes and types for the postfix stack evaluator.
// No dependencies; imported by every module of the block.
package pse_pkg;

	localparam int DATA_WIDTH  = 32;
	localparam int STACK_DEPTH = 64;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int DIV_CNT_W   = $clog2(DATA_WIDTH + 1);
	localparam int TDATA_W     = ((DATA_WIDTH + 7) / 8) * 8;

	typedef enum logic [2:0] {
		FN_PUSH    = 3'd0,
		FN_ADD     = 3'd1,
		FN_SUB     = 3'd2,
		FN_MUL     = 3'd3,
		FN_DIV     = 3'd4,
		FN_MOD     = 3'd5,
		FN_UNKNOWN = 3'd6,
		FN_FINISH  = 3'd7
	} func_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2,
		ST_DIVZ  = 2'd3
	} status_t;

	// Per-cell move: take the neighbor toward the top, or toward the bottom.
	typedef struct packed {
		logic take_prev;
		logic take_next;
	} cell_ctl_t;

endpackage

@@ src/pse_cell.sv @@
// One stack cell: holds one entry and shifts with its neighbors.
// Depends on pse_pkg.
module pse_cell
	import pse_pkg::*;
(
	input  logic                  clk,
	input  cell_ctl_t             ctl,
	input  logic [DATA_WIDTH-1:0] prev,
	input  logic [DATA_WIDTH-1:0] next,
	output logic [DATA_WIDTH-1:0] data
);

	logic [DATA_WIDTH-1:0] data_q;

	always_ff @(posedge clk) begin
		priority if (ctl.take_prev) begin
			data_q <= prev;
		end else if (ctl.take_next) begin
			data_q <= next;
		end else begin
			data_q <= data_q;
		end
	end

	assign data = data_q;

endmodule

@@ src/pse_div.sv @@
// Iterative signed divide/modulo, one quotient bit per cycle, truncating.
// Depends on pse_pkg.
module pse_div
	import pse_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic                  want_mod,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  done,
	output logic [DATA_WIDTH-1:0] result
);

	logic                  busy_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] den_q;
	logic                  an_q;
	logic                  bn_q;
	logic                  mod_q;

	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH:0]   diff;
	logic [DATA_WIDTH-1:0] mag_a;
	logic [DATA_WIDTH-1:0] mag_b;
	logic                  last_step;

	assign mag_a     = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
	assign mag_b     = divisor[DATA_WIDTH-1] ? (~divisor + 1'b1) : divisor;
	assign shifted   = {rem_q, quo_q[DATA_WIDTH-1]};
	assign diff      = shifted - {1'b0, den_q};
	assign last_step = (cnt_q == DIV_CNT_W'(DATA_WIDTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (last_step) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= mag_a;
			den_q <= mag_b;
			an_q  <= dividend[DATA_WIDTH-1];
			bn_q  <= divisor[DATA_WIDTH-1];
			mod_q <= want_mod;
		end else if (busy_q && !last_step) begin
			// restore when the trial subtract goes negative
			rem_q <= diff[DATA_WIDTH] ? shifted[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
			quo_q <= {quo_q[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
		end
	end

	assign done = busy_q && last_step;

	always_comb begin
		if (mod_q) begin
			result = an_q ? (~rem_q + 1'b1) : rem_q;
		end else begin
			result = (an_q != bn_q) ? (~quo_q + 1'b1) : quo_q;
		end
	end

endmodule

@@ src/postfix_stack_evaluator_unit.sv @@
// Postfix (RPN) evaluator top level: request handshake, control and the cell chain.
// Depends on pse_pkg, pse_cell and pse_div.
//
// Each request carries one token: tuser selects push, add, sub, mul, div, mod,
// unknown operator or finish; tdata holds the operand for a push. The operand
// stack is a chain of STACK_DEPTH cells that shifts down on a push and up on a
// pop, so the top two entries are always in the first two cells. A push or a
// add/sub/mul/unknown operator is accepted in idle, then executed; divide and
// modulo then wait while the divider makes one quotient bit per cycle (a zero
// divisor skips the divider). A finish token gives one result with the top
// value and the first error, then empties the stack; it holds in execute until
// the output register is free. No clearing pass runs after reset.
module postfix_stack_evaluator_unit
	import pse_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [TDATA_W-1:0] s_tdata,   // [31:0] operand_value
	input  logic [2:0]         s_tuser,   // [2:0] func
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // [31:0] final_value
	output logic [1:0]         m_tuser    // [1:0] status
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_DIVW
	} state_t;

	state_t                state_q;
	func_t                 func_q;
	logic [DATA_WIDTH-1:0] val_q;
	logic [CNT_W-1:0]      cnt_q;
	status_t               err_q;
	logic                  m_tvalid_q;
	logic [DATA_WIDTH-1:0] m_data_q;
	status_t               m_status_q;

	logic [DATA_WIDTH-1:0] cell_data [STACK_DEPTH];
	cell_ctl_t             ctl_top;
	cell_ctl_t             ctl_rest;
	logic [DATA_WIDTH-1:0] top_in;

	logic                  have1;
	logic                  have2;
	logic [DATA_WIDTH-1:0] op_a;
	logic [DATA_WIDTH-1:0] op_b;
	logic [DATA_WIDTH-1:0] alu_res;
	logic                  div_start;
	logic                  div_done;
	logic [DATA_WIDTH-1:0] div_res;

	logic                  commit;
	logic [DATA_WIDTH-1:0] commit_val;
	logic                  do_push;
	logic                  do_finish;
	logic                  out_free;
	status_t               err_next;

	assign have1    = (cnt_q != '0);
	assign have2    = (cnt_q > CNT_W'(1));
	assign op_b     = have1 ? cell_data[0] : '0;
	assign op_a     = have2 ? cell_data[1] : '0;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		unique case (func_q)
			FN_ADD:  alu_res = op_a + op_b;
			FN_SUB:  alu_res = op_a - op_b;
			FN_MUL:  alu_res = DATA_WIDTH'(op_a * op_b);
			default: alu_res = '0;
		endcase
	end

	pse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.want_mod (func_q == FN_MOD),
		.dividend (op_a),
		.divisor  (op_b),
		.done     (div_done),
		.result   (div_res)
	);

	// Decide what the current token does this cycle.
	always_comb begin
		commit     = 1'b0;
		commit_val = alu_res;
		do_push    = 1'b0;
		do_finish  = 1'b0;
		div_start  = 1'b0;
		err_next   = err_q;
		if (state_q == S_EXEC) begin
			unique case (func_q)
				FN_PUSH: begin
					if (cnt_q == CNT_W'(STACK_DEPTH)) begin
						if (err_q == ST_OK) err_next = ST_OVER;
					end else begin
						do_push = 1'b1;
					end
				end
				FN_FINISH: begin
					do_finish = out_free;
				end
				FN_DIV, FN_MOD: begin
					if (op_b == '0) begin
						commit     = 1'b1;
						commit_val = '0;
						if (err_q == ST_OK) err_next = have2 ? ST_DIVZ : ST_UNDER;
					end else begin
						div_start = 1'b1;
						if (err_q == ST_OK && !have2) err_next = ST_UNDER;
					end
				end
				FN_ADD, FN_SUB, FN_MUL, FN_UNKNOWN: begin
					commit = 1'b1;
					if (err_q == ST_OK && !have2) err_next = ST_UNDER;
				end
			endcase
		end else if (state_q == S_DIVW && div_done) begin
			commit     = 1'b1;
			commit_val = div_res;
		end
	end

	// Cell chain moves: push shifts everything down; an operator writes its
	// result to the top and pulls the rest up when two operands were popped.
	always_comb begin
		ctl_top  = '0;
		ctl_rest = '0;
		top_in   = commit_val;
		if (do_push) begin
			top_in             = val_q;
			ctl_top.take_prev  = 1'b1;
			ctl_rest.take_prev = 1'b1;
		end else if (commit) begin
			ctl_top.take_prev  = 1'b1;
			ctl_rest.take_next = have2;
		end
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] prev_d;
		logic [DATA_WIDTH-1:0] next_d;
		if (i == 0) begin : g_first
			assign prev_d = top_in;
		end else begin : g_mid
			assign prev_d = cell_data[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_inner
			assign next_d = cell_data[i+1];
		end
		pse_cell u_cell (
			.clk  (clk),
			.ctl  ((i == 0) ? ctl_top : ctl_rest),
			.prev (prev_d),
			.next (next_d),
			.data (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			err_q      <= ST_OK;
			m_tvalid_q <= 1'b0;
		end else begin
			err_q <= do_finish ? ST_OK : err_next;
			if (do_finish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (div_start) begin
						state_q <= S_DIVW;
					end else if (func_q != FN_FINISH || do_finish) begin
						state_q <= S_IDLE;
					end
				end
				S_DIVW: begin
					if (div_done) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (do_finish) begin
				cnt_q <= '0;
			end else if (do_push) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (commit) begin
				cnt_q <= have2 ? (cnt_q - 1'b1) : CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_q <= func_t'(s_tuser);
			val_q  <= s_tdata[DATA_WIDTH-1:0];
		end
		if (do_finish) begin
			m_data_q   <= op_b;
			m_status_q <= (err_q != ST_OK) ? err_q : (have1 ? ST_OK : ST_UNDER);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = TDATA_W'(m_data_q);
	assign m_tuser  = m_status_q;

endmodule
